### rtl/core/seven_segment_number_formatter_macros.svh
// Assertion macros for the seven-segment number formatter.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef SEVEN_SEGMENT_NUMBER_FORMATTER_MACROS_SVH
`define SEVEN_SEGMENT_NUMBER_FORMATTER_MACROS_SVH

// Same-cycle implication, quiet during reset
`define SSEG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset
`define SSEG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/sseg_pkg.sv
// Shared types, segment codes and digit helpers for the number formatter.
// No dependencies; used by sseg_dec, sseg_hex and the top level.
`default_nettype none

package sseg_pkg;

  typedef logic [3:0][7:0] seg4_t;  // index 0 is the leftmost digit

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_ERR    = 2'd1,
    ST_LO     = 2'd2,
    ST_HI     = 2'd3
  } status_t;

  typedef struct packed {
    seg4_t      seg;
    logic [2:0] digits;
    status_t    status;
  } fmt_t;

  localparam logic OP_DEC = 1'b0;
  localparam logic OP_HEX = 1'b1;

  localparam logic [7:0] SEG_POINT = 8'h80;
  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_E     = 8'h79;
  localparam logic [7:0] SEG_R     = 8'h05;
  localparam logic [7:0] SEG_L     = 8'h38;
  localparam logic [7:0] SEG_O     = 8'h3f;
  localparam logic [7:0] SEG_H     = 8'h76;
  localparam logic [7:0] SEG_I     = 8'h30;

  localparam logic [15:0]        DEC_MAX = 16'd9999;
  localparam logic signed [15:0] DEC_MIN = -16'sd999;

  // floor(x / 100) = (x * 5243) >> 19 for x below 10000
  localparam logic [12:0] RECIP_100 = 13'd5243;
  // floor(x / 10) = (x * 205) >> 11 for x below 128
  localparam logic [7:0]  RECIP_10  = 8'd205;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'h0: g = 8'h3f;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5b;
      4'h3: g = 8'h4f;
      4'h4: g = 8'h66;
      4'h5: g = 8'h6d;
      4'h6: g = 8'h7d;
      4'h7: g = 8'h07;
      4'h8: g = 8'h7f;
      4'h9: g = 8'h6f;
      4'ha: g = 8'h77;
      4'hb: g = 8'h7c;
      4'hc: g = 8'h39;
      4'hd: g = 8'h5e;
      4'he: g = 8'h79;
      default: g = 8'h71;
    endcase
    return g;
  endfunction

  // Split a value below 100 into {tens, units}
  function automatic logic [7:0] split_tens(input logic [6:0] x);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  u;
    p = 15'(x) * 15'(RECIP_10);
    t = p[14:11];
    u = x - 7'(7'(t) * 7'd10);
    return {t, u[3:0]};
  endfunction

endpackage

`default_nettype wire

### rtl/core/sseg_dec.sv
// Signed decimal formatting: range checks, digit split, point and minus.
// Depends on sseg_pkg.
`default_nettype none

module sseg_dec (
  input  wire logic [15:0]  value,
  input  wire logic [7:0]   places,
  output sseg_pkg::fmt_t    fmt
);
  import sseg_pkg::*;

  logic        neg;
  logic        err;
  logic        lo;
  logic        hi;
  logic [15:0] mag16;
  logic [13:0] mag;
  logic [26:0] prod;
  logic [6:0]  hund;
  logic [13:0] rem;
  logic [7:0]  hi_pair;
  logic [7:0]  lo_pair;
  logic [3:0][3:0] dig;  // index 0 is the units digit
  logic [2:0]  sig;
  logic [2:0]  need;
  logic [2:0]  n_dig;
  seg4_t       seg;

  assign neg   = value[15];
  assign err   = (|places[7:2]) || ((places[1:0] == 2'd3) && neg);
  assign lo    = $signed(value) < DEC_MIN;
  assign hi    = !neg && (value > DEC_MAX);
  assign mag16 = neg ? 16'(~value + 16'd1) : value;
  assign mag   = mag16[13:0];

  // Split into hundreds and remainder, then each into two digits
  assign prod    = 27'(mag) * 27'(RECIP_100);
  assign hund    = prod[25:19];
  assign rem     = 14'(mag - 14'(14'(hund) * 14'd100));
  assign hi_pair = split_tens(hund);
  assign lo_pair = split_tens(rem[6:0]);
  assign dig[3]  = hi_pair[7:4];
  assign dig[2]  = hi_pair[3:0];
  assign dig[1]  = lo_pair[7:4];
  assign dig[0]  = lo_pair[3:0];

  always_comb begin
    priority if (dig[3] != 4'd0) sig = 3'd4;
    else if (dig[2] != 4'd0)     sig = 3'd3;
    else if (dig[1] != 4'd0)     sig = 3'd2;
    else if (mag != 14'd0)       sig = 3'd1;
    else                         sig = 3'd0;
  end

  // Pad with zeros up to the units digit
  assign need  = 3'(places[1:0]) + 3'd1;
  assign n_dig = (sig > need) ? sig : need;

  always_comb begin
    seg = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < n_dig) begin
        seg[2'(3 - k)] = glyph(dig[k]);
      end
      if ((places[1:0] != 2'd0) && (2'(k) == places[1:0])) begin
        seg[2'(3 - k)] = seg[2'(3 - k)] | SEG_POINT;
      end
      if (neg && (3'(k) == n_dig)) begin
        seg[2'(3 - k)] = SEG_MINUS;
      end
    end
  end

  always_comb begin
    fmt = '0;
    priority if (err) begin
      fmt.seg[1] = SEG_E;
      fmt.seg[2] = SEG_R;
      fmt.seg[3] = SEG_R;
      fmt.digits = 3'd3;
      fmt.status = ST_ERR;
    end else if (lo) begin
      fmt.seg[2] = SEG_L;
      fmt.seg[3] = SEG_O;
      fmt.digits = 3'd2;
      fmt.status = ST_LO;
    end else if (hi) begin
      fmt.seg[2] = SEG_H;
      fmt.seg[3] = SEG_I;
      fmt.digits = 3'd2;
      fmt.status = ST_HI;
    end else begin
      fmt.seg    = seg;
      fmt.digits = (neg && (n_dig < 3'd4)) ? 3'(n_dig + 3'd1) : n_dig;
      fmt.status = ST_NORMAL;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sseg_hex.sv
// Unsigned hexadecimal formatting with optional zero padding.
// Depends on sseg_pkg.
`default_nettype none

module sseg_hex (
  input  wire logic [15:0]  value,
  input  wire logic         lead_zeros,
  output sseg_pkg::fmt_t    fmt
);
  import sseg_pkg::*;

  logic [2:0] n_dig;

  always_comb begin
    priority if (lead_zeros)      n_dig = 3'd4;
    else if (value[15:12] != 4'd0) n_dig = 3'd4;
    else if (value[11:8] != 4'd0)  n_dig = 3'd3;
    else if (value[7:4] != 4'd0)   n_dig = 3'd2;
    else                           n_dig = 3'd1;  // zero still lights one digit
  end

  always_comb begin
    fmt = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < n_dig) begin
        fmt.seg[2'(3 - k)] = glyph(value[4*k +: 4]);
      end
    end
    fmt.digits = n_dig;
    fmt.status = ST_NORMAL;
  end

endmodule

`default_nettype wire

### rtl/core/seven_segment_number_formatter.sv
// Top level of the four-digit seven-segment number formatter.
// Depends on sseg_pkg, sseg_dec, sseg_hex and the assertion macro header.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid, in_stall, in_opcode, in_value,     | request in
//           | in_places, in_lead_zeros                     |
//   out     | out_valid, out_stall, out_seg_*, out_status, | result out
//           | out_active_digits                            |
//
// One request a cycle while in_stall is low; each taken request passes through the input register,
// then the formatting logic into the result register, before it reaches the outputs.
// The decimal path's constant divide-by-100 multiply sets the cycle time.
// Synchronous active-low reset empties both stages.
// A stalled result holds; the input register keeps taking requests while
// the result register has room or the input register is empty.
`default_nettype none
`include "seven_segment_number_formatter_macros.svh"

module seven_segment_number_formatter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [15:0] in_value,
  input  wire logic [7:0]  in_places,
  input  wire logic        in_lead_zeros,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_seg_left,
  output logic [7:0]       out_seg_mid_left,
  output logic [7:0]       out_seg_mid_right,
  output logic [7:0]       out_seg_right,
  output logic [2:0]       out_active_digits,
  output logic [1:0]       out_status
);
  import sseg_pkg::*;

  logic        s1_v_r, s1_v_nxt;
  logic        s1_op_r;
  logic [15:0] s1_value_r;
  logic [7:0]  s1_places_r;
  logic        s1_lz_r;
  logic        s2_v_r, s2_v_nxt;
  fmt_t        s2_fmt_r, s2_fmt_nxt;
  logic        s2_load;
  logic        in_take;
  fmt_t        dec_fmt;
  fmt_t        hex_fmt;

  assign s2_load  = !s2_v_r || !out_stall;
  assign in_stall = s1_v_r && !s2_load;
  assign in_take  = in_valid && !in_stall;

  sseg_dec u_dec (
    .value  (s1_value_r),
    .places (s1_places_r),
    .fmt    (dec_fmt)
  );

  sseg_hex u_hex (
    .value      (s1_value_r),
    .lead_zeros (s1_lz_r),
    .fmt        (hex_fmt)
  );

  assign s2_fmt_nxt = (s1_op_r == OP_HEX) ? hex_fmt : dec_fmt;

  always_comb begin
    if (in_take) begin
      s1_v_nxt = 1'b1;
    end else if (s2_load) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
    s2_v_nxt = s2_load ? s1_v_r : s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r     <= in_opcode;
      s1_value_r  <= in_value;
      s1_places_r <= in_places;
      s1_lz_r     <= in_lead_zeros;
    end
    if (s2_load) begin
      s2_fmt_r <= s2_fmt_nxt;
    end
  end

  assign out_valid         = s2_v_r;
  assign out_seg_left      = s2_fmt_r.seg[0];
  assign out_seg_mid_left  = s2_fmt_r.seg[1];
  assign out_seg_mid_right = s2_fmt_r.seg[2];
  assign out_seg_right     = s2_fmt_r.seg[3];
  assign out_active_digits = s2_fmt_r.digits;
  assign out_status        = s2_fmt_r.status;

  // Every result lights at least one digit
  `SSEG_ASSERT_IMP(a_digits_lit, out_valid, out_active_digits != 3'd0, "no digit lit")
  // Err, LO and HI never reach the leftmost digit
  `SSEG_ASSERT_IMP(a_status_left_blank, out_valid && (out_status != ST_NORMAL),
                   out_seg_left == 8'h00, "status code with leftmost digit lit")
  // HI and LO light exactly two digits
  `SSEG_ASSERT_IMP(a_range_two_digits,
                   out_valid && ((out_status == ST_HI) || (out_status == ST_LO)),
                   out_active_digits == 3'd2, "range code digit count wrong")
  // A request held back in the input register is not dropped
  `SSEG_ASSERT_NXT(a_hold_input, s1_v_r && in_stall, s1_v_r, "held request lost")

endmodule

`default_nettype wire
